>>> hw/rtl/mcmf_pkg.sv
// ============================================================================
// mcmf_pkg
// Shared field widths, command codes and status codes for the multi-channel
// message queue core and its checker.
// ============================================================================
package mcmf_pkg;

    // Field widths of the command and result words.
    localparam int CMD_W  = 2;
    localparam int CH_W   = 2;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int ST_W   = 3;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Status codes carried by every result word.
    localparam logic [ST_W-1:0] ST_WRITTEN = 3'd0;
    localparam logic [ST_W-1:0] ST_READ    = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [ST_W-1:0] ST_SMALL   = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;
    localparam logic [ST_W-1:0] ST_LONG    = 3'd5;
    localparam logic [ST_W-1:0] ST_CLEARED = 3'd6;

    // Strobes from the sequencer to the storage block.
    typedef struct packed {
        logic byte_we;
        logic byte_re;
        logic len_we;
    } store_ctl_t;

endpackage

>>> hw/rtl/multi_channel_message_fifo_core.sv
// ============================================================================
// multi_channel_message_fifo_core
// Per-channel ring queues of variable-length byte messages with a command
// port and a strobed result port.
// ============================================================================
// A command is taken when start is high and busy is low; results come out one
// word per cycle marked by strobe and cannot be held off. A write byte or a
// clear passes through two steps (take the command, then update state and
// storage), and busy stays high during the update, so no new byte is taken then.
// A read passes through three steps up to its decision (take, look up the slot
// length, decide), and a read that delivers bytes keeps the block busy while it
// streams them, since the single byte memory port returns one byte per cycle.
// All slot and byte addresses come from one shared address unit. Results appear
// in the cycle after the sequencer produces them, so the final word of a read
// may be on the port while the next command is already being taken.
module multi_channel_message_fifo_core
    import mcmf_pkg::*;
#(
    parameter int CHANNELS  = 4,
    parameter int SLOTS     = 8,
    parameter int MAX_BYTES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  command,
    input  logic [CH_W-1:0]   channel,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              end_of_message,
    input  logic [LEN_W-1:0]  read_capacity,
    output logic              strobe,
    output logic [ST_W-1:0]   status,
    output logic [BYTE_W-1:0] out_byte,
    output logic [LEN_W-1:0]  length,
    output logic              last
);

    localparam int CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW         = $clog2(SLOTS);
    localparam int CNTW       = $clog2(SLOTS + 1);
    localparam int OW         = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int LW         = $clog2(MAX_BYTES + 1);
    localparam int SLOT_COUNT = CHANNELS * SLOTS;
    localparam int BYTE_DEPTH = SLOT_COUNT * MAX_BYTES;
    localparam int SAW        = $clog2(SLOT_COUNT);
    localparam int BAW        = $clog2(BYTE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOOK,
        S_STREAM
    } state_t;

    state_t state_reg, state_next;

    // Latched command word.
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              eom_reg, eom_next;
    logic [LEN_W-1:0]  cap_reg, cap_next;

    // Queue state per channel: ring pointers and fill count.
    logic [IW-1:0]   head_reg [CHANNELS];
    logic [IW-1:0]   head_next [CHANNELS];
    logic [IW-1:0]   tail_reg [CHANNELS];
    logic [IW-1:0]   tail_next [CHANNELS];
    logic [CNTW-1:0] count_reg [CHANNELS];
    logic [CNTW-1:0] count_next [CHANNELS];

    // Message in progress and read streaming.
    logic [LW-1:0] wcount_reg, wcount_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] emit_reg, emit_next;

    // Registered result word.
    logic              strobe_reg, strobe_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic              last_reg, last_next;

    // Address unit and storage connections.
    logic [CW-1:0]     ch_idx;
    logic              ch_ok;
    logic [IW-1:0]     ring_idx;
    logic [OW-1:0]     offset;
    logic [SAW-1:0]    slot_addr;
    logic [BAW-1:0]    byte_addr;
    logic [BYTE_W-1:0] byte_rdata;
    logic [LW-1:0]     len_rdata;
    logic [LW-1:0]     len_wdata;
    store_ctl_t        ctl;

    // Derived values used by the sequencer.
    logic          slot_full;
    logic          wc_at_max;
    logic [LW-1:0] wc_inc;
    logic [LW-1:0] emit_inc;

    assign ch_idx    = CW'(ch_reg);
    assign ch_ok     = (32'(ch_reg) < CHANNELS);
    assign ring_idx  = (cmd_reg == CMD_WRITE) ? head_reg[ch_idx] : tail_reg[ch_idx];
    assign slot_full = (count_reg[ch_idx] == CNTW'(SLOTS));
    assign wc_at_max = (wcount_reg >= LW'(MAX_BYTES));
    assign wc_inc    = wcount_reg + LW'(1);
    assign emit_inc  = emit_reg + LW'(1);
    assign len_wdata = wc_inc;

    // Byte offset: write position, start of message, or next byte of a stream.
    always_comb
    begin
        if (state_reg == S_STREAM)
        begin
            offset = emit_inc[OW-1:0];
        end
        else if (cmd_reg == CMD_WRITE)
        begin
            offset = wcount_reg[OW-1:0];
        end
        else
        begin
            offset = '0;
        end
    end

    mcmf_addr #(
        .SLOTS     (SLOTS),
        .MAX_BYTES (MAX_BYTES),
        .CW        (CW),
        .IW        (IW),
        .OW        (OW),
        .SAW       (SAW),
        .BAW       (BAW)
    ) u_addr (
        .ch        (ch_idx),
        .idx       (ring_idx),
        .offset    (offset),
        .slot_addr (slot_addr),
        .byte_addr (byte_addr)
    );

    mcmf_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .BYTE_DEPTH (BYTE_DEPTH),
        .SAW        (SAW),
        .BAW        (BAW),
        .LW         (LW)
    ) u_store (
        .clk        (clk),
        .ctl        (ctl),
        .byte_addr  (byte_addr),
        .byte_wdata (byte_reg),
        .byte_rdata (byte_rdata),
        .slot_addr  (slot_addr),
        .len_wdata  (len_wdata),
        .len_rdata  (len_rdata)
    );

    // Sequencer: next state, queue updates, storage strobes and result word.
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        ch_next       = ch_reg;
        byte_next     = byte_reg;
        eom_next      = eom_reg;
        cap_next      = cap_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        wcount_next   = wcount_reg;
        ovf_next      = ovf_reg;
        len_next      = len_reg;
        emit_next     = emit_reg;
        strobe_next   = 1'b0;
        status_next   = status_reg;
        out_byte_next = out_byte_reg;
        length_next   = length_reg;
        last_next     = last_reg;
        ctl           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    ch_next    = channel;
                    byte_next  = in_byte;
                    eom_next   = end_of_message;
                    cap_next   = read_capacity;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                if (cmd_reg == CMD_CLEAR)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        head_next[c]  = '0;
                        tail_next[c]  = '0;
                        count_next[c] = '0;
                    end
                    wcount_next   = '0;
                    ovf_next      = 1'b0;
                    strobe_next   = 1'b1;
                    status_next   = ST_CLEARED;
                    out_byte_next = '0;
                    length_next   = '0;
                    last_next     = 1'b1;
                end
                else if (cmd_reg == CMD_WRITE && ch_ok)
                begin
                    // Store the byte unless the message is already too long
                    // or the head slot still holds an unread message.
                    if (wc_at_max)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ctl.byte_we = !slot_full;
                        wcount_next = wc_inc;
                    end
                    if (eom_reg)
                    begin
                        strobe_next   = 1'b1;
                        out_byte_next = '0;
                        length_next   = '0;
                        last_next     = 1'b1;
                        if (ovf_reg || wc_at_max)
                        begin
                            status_next = ST_LONG;
                        end
                        else if (slot_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctl.len_we = 1'b1;
                            count_next[ch_idx] = count_reg[ch_idx] + CNTW'(1);
                            head_next[ch_idx]  =
                                (head_reg[ch_idx] == IW'(SLOTS - 1)) ?
                                '0 : head_reg[ch_idx] + IW'(1);
                            status_next = ST_WRITTEN;
                            length_next = LEN_W'(wc_inc);
                        end
                        wcount_next = '0;
                        ovf_next    = 1'b0;
                    end
                end
                else if (cmd_reg == CMD_READ && ch_ok)
                begin
                    // Fetch the first byte while the length comes back.
                    ctl.byte_re = 1'b1;
                    state_next  = S_LOOK;
                end
            end

            S_LOOK:
            begin
                len_next  = len_rdata;
                emit_next = '0;
                if (count_reg[ch_idx] == '0)
                begin
                    strobe_next   = 1'b1;
                    status_next   = ST_EMPTY;
                    out_byte_next = '0;
                    length_next   = '0;
                    last_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (LEN_W'(len_rdata) > cap_reg)
                begin
                    strobe_next   = 1'b1;
                    status_next   = ST_SMALL;
                    out_byte_next = '0;
                    length_next   = '0;
                    last_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_STREAM;
                end
            end

            S_STREAM:
            begin
                // Deliver the byte held in the read register and fetch the next one while bytes remain.
                strobe_next   = 1'b1;
                status_next   = ST_READ;
                out_byte_next = byte_rdata;
                length_next   = LEN_W'(len_reg);
                last_next     = (emit_inc == len_reg);
                ctl.byte_re   = (emit_inc < len_reg);
                emit_next     = emit_inc;
                if (emit_inc == len_reg)
                begin
                    count_next[ch_idx] = count_reg[ch_idx] - CNTW'(1);
                    tail_next[ch_idx]  =
                        (tail_reg[ch_idx] == IW'(SLOTS - 1)) ?
                        '0 : tail_reg[ch_idx] + IW'(1);
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, queue pointers and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= CMD_CLEAR;
            ch_reg    <= '0;
            byte_reg  <= '0;
            eom_reg   <= 1'b0;
            cap_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                head_reg[c]  <= '0;
                tail_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
            wcount_reg   <= '0;
            ovf_reg      <= 1'b0;
            len_reg      <= '0;
            emit_reg     <= '0;
            strobe_reg   <= 1'b0;
            status_reg   <= ST_WRITTEN;
            out_byte_reg <= '0;
            length_reg   <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            ch_reg       <= ch_next;
            byte_reg     <= byte_next;
            eom_reg      <= eom_next;
            cap_reg      <= cap_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            wcount_reg   <= wcount_next;
            ovf_reg      <= ovf_next;
            len_reg      <= len_next;
            emit_reg     <= emit_next;
            strobe_reg   <= strobe_next;
            status_reg   <= status_next;
            out_byte_reg <= out_byte_next;
            length_reg   <= length_next;
            last_reg     <= last_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign strobe   = strobe_reg;
    assign status   = status_reg;
    assign out_byte = out_byte_reg;
    assign length   = length_reg;
    assign last     = last_reg;

endmodule

>>> hw/rtl/mcmf_addr.sv
// ============================================================================
// mcmf_addr
// Shared address unit: maps a channel, a ring index and a byte offset to the
// slot address and the byte address in storage.
// ============================================================================
module mcmf_addr #(
    parameter int SLOTS     = 8,
    parameter int MAX_BYTES = 64,
    parameter int CW        = 2,
    parameter int IW        = 3,
    parameter int OW        = 6,
    parameter int SAW       = 5,
    parameter int BAW       = 11
) (
    input  logic [CW-1:0]  ch,
    input  logic [IW-1:0]  idx,
    input  logic [OW-1:0]  offset,
    output logic [SAW-1:0] slot_addr,
    output logic [BAW-1:0] byte_addr
);

    localparam int CH_STRIDE = SLOTS * MAX_BYTES;

    // All products are by constants and run side by side, not chained.
    assign slot_addr = SAW'(BAW'(ch) * BAW'(SLOTS) + BAW'(idx));
    assign byte_addr = BAW'(ch) * BAW'(CH_STRIDE) + BAW'(idx) * BAW'(MAX_BYTES)
                     + BAW'(offset);

endmodule

>>> hw/rtl/mcmf_store.sv
// ============================================================================
// mcmf_store
// Message storage: the byte memory of all slots and the length memory with
// one entry per slot. Both reads are registered.
// ============================================================================
module mcmf_store
    import mcmf_pkg::*;
#(
    parameter int SLOT_COUNT = 32,
    parameter int BYTE_DEPTH = 2048,
    parameter int SAW        = 5,
    parameter int BAW        = 11,
    parameter int LW         = 7
) (
    input  logic              clk,
    input  store_ctl_t        ctl,
    input  logic [BAW-1:0]    byte_addr,
    input  logic [BYTE_W-1:0] byte_wdata,
    output logic [BYTE_W-1:0] byte_rdata,
    input  logic [SAW-1:0]    slot_addr,
    input  logic [LW-1:0]     len_wdata,
    output logic [LW-1:0]     len_rdata
);

    logic [BYTE_W-1:0] byte_mem [BYTE_DEPTH];
    logic [LW-1:0]     len_mem  [SLOT_COUNT];

    // Byte memory: one write or one read per cycle at the shared address.
    always_ff @(posedge clk)
    begin
        if (ctl.byte_we)
        begin
            byte_mem[byte_addr] <= byte_wdata;
        end
        if (ctl.byte_re)
        begin
            byte_rdata <= byte_mem[byte_addr];
        end
    end

    // Length memory: written on commit, read every cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.len_we)
        begin
            len_mem[slot_addr] <= len_wdata;
        end
        len_rdata <= len_mem[slot_addr];
    end

endmodule

>>> hw/rtl/mcmf_checker.sv
// ============================================================================
// mcmf_checker
// Port-level checks of the message queue core, attached to every instance of
// the top level by a bind statement.
// ============================================================================
module mcmf_checker
    import mcmf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              strobe,
    input logic [ST_W-1:0]   status,
    input logic [BYTE_W-1:0] out_byte,
    input logic [LEN_W-1:0]  length,
    input logic              last
);

    // A taken command always makes busy high in the cycle after it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
    else $error("busy did not rise after a command was taken");

    // Every status other than a read byte is a single, final word.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status != ST_READ |-> last)
    else $error("non-read result word without last");

    // Answers without data carry zero byte and zero length.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status == ST_EMPTY || status == ST_SMALL || status == ST_FULL ||
                   status == ST_LONG || status == ST_CLEARED)
        |-> out_byte == '0 && length == '0)
    else $error("data fields not zero on an answer without data");

    // A read stream runs without gaps and keeps its length until last.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == ST_READ && !last
        |=> strobe && status == ST_READ && $stable(length))
    else $error("read stream broken before its last word");

    // A read word never reports a length of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == ST_READ |-> length != '0)
    else $error("read word with zero length");

endmodule

bind multi_channel_message_fifo_core mcmf_checker u_mcmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .strobe   (strobe),
    .status   (status),
    .out_byte (out_byte),
    .length   (length),
    .last     (last)
);

>>> tb/tb_multi_channel_message_fifo_core.sv
// ============================================================================
// tb_multi_channel_message_fifo_core
// Self-checking bench for the multi-channel message queue core. Directed tasks
// cover empty reads, capacity limits, full queues, overlong messages, channel
// hops, stale slot bytes and clears. A random phase then mixes well-formed
// messages with partial messages, reads, clears and unused commands. Every
// accepted command word is run through a behavioral queue predictor, and
// every strobed result word is compared field by field with the oldest
// predicted word.
// ============================================================================
module tb_multi_channel_message_fifo_core;
    import mcmf_pkg::*;

    localparam int N_CH         = 4;
    localparam int N_SLOTS      = 8;
    localparam int MSG_MAX      = 64;
    localparam int RANDOM_ITEMS = 50;
    localparam int MAX_REPORTS  = 40;

    // The one command code that the package leaves unnamed.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              fin;
    } response_t;

    logic              clk;
    logic              rst_n          = 1'b0;
    logic              start          = 1'b0;
    logic [CMD_W-1:0]  command        = CMD_CLEAR;
    logic [CH_W-1:0]   channel        = '0;
    logic [BYTE_W-1:0] in_byte        = '0;
    logic              end_of_message = 1'b0;
    logic [LEN_W-1:0]  read_capacity  = '0;
    logic              busy;
    logic              strobe;
    logic [ST_W-1:0]   status;
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  length;
    logic              last;

    // Set at the falling edge when the coming rising edge takes a word.
    logic              taken = 1'b0;

    // Predicted queue contents and write progress.
    logic [BYTE_W-1:0] slot_data    [N_CH][N_SLOTS][MSG_MAX];
    bit                slot_written [N_CH][N_SLOTS][MSG_MAX];
    int                slot_len     [N_CH][N_SLOTS];
    bit                slot_full    [N_CH][N_SLOTS];
    int                head_ptr     [N_CH];
    int                tail_ptr     [N_CH];
    int                fill_count;
    bit                fill_overflow;

    response_t         pending_responses[$];

    int                err_count;
    int                items_sent;
    int                burst_left;
    int                status_seen[8];

    multi_channel_message_fifo_core #(
        .CHANNELS  (N_CH),
        .SLOTS     (N_SLOTS),
        .MAX_BYTES (MSG_MAX)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .channel        (channel),
        .in_byte        (in_byte),
        .end_of_message (end_of_message),
        .read_capacity  (read_capacity),
        .strobe         (strobe),
        .status         (status),
        .out_byte       (out_byte),
        .length         (length),
        .last           (last)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("Timeout: results still outstanding");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Print one mismatch line, up to a limit, and count it.
    task automatic report_error(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    function automatic void push_response(input logic [ST_W-1:0] st,
                                          input logic [BYTE_W-1:0] data,
                                          input int len, input logic fin);
        response_t r;
        r.status = st;
        r.data   = data;
        r.len    = len[LEN_W-1:0];
        r.fin    = fin;
        pending_responses.push_back(r);
    endfunction

    // Update the predicted queues for one accepted word and queue its results.
    function automatic void predict_responses(input logic [CMD_W-1:0] cmd,
                                              input logic [CH_W-1:0] ch_in,
                                              input logic [BYTE_W-1:0] data,
                                              input logic eom,
                                              input logic [LEN_W-1:0] cap);
        int ch;
        int slot;
        int lim;
        ch = ch_in;
        case (cmd)
            CMD_CLEAR:
            begin
                foreach (slot_full[c, s])
                    slot_full[c][s] = 1'b0;
                foreach (head_ptr[c])
                begin
                    head_ptr[c] = 0;
                    tail_ptr[c] = 0;
                end
                fill_count    = 0;
                fill_overflow = 1'b0;
                push_response(ST_CLEARED, '0, 0, 1'b1);
            end
            CMD_WRITE:
            begin
                slot = head_ptr[ch];
                // Bytes past the size limit only mark the message as too long.
                if (fill_count >= MSG_MAX)
                    fill_overflow = 1'b1;
                else
                begin
                    if (!slot_full[ch][slot])
                    begin
                        slot_data[ch][slot][fill_count]    = data;
                        slot_written[ch][slot][fill_count] = 1'b1;
                    end
                    fill_count++;
                end
                if (eom)
                begin
                    if (fill_overflow)
                        push_response(ST_LONG, '0, 0, 1'b1);
                    else if (slot_full[ch][slot])
                        push_response(ST_FULL, '0, 0, 1'b1);
                    else
                    begin
                        slot_len[ch][slot]  = fill_count;
                        slot_full[ch][slot] = 1'b1;
                        head_ptr[ch]        = (head_ptr[ch] + 1) % N_SLOTS;
                        push_response(ST_WRITTEN, '0, fill_count, 1'b1);
                    end
                    fill_count    = 0;
                    fill_overflow = 1'b0;
                end
            end
            CMD_READ:
            begin
                slot = tail_ptr[ch];
                lim  = (cap > MSG_MAX) ? MSG_MAX : int'(cap);
                if (!slot_full[ch][slot])
                    push_response(ST_EMPTY, '0, 0, 1'b1);
                else if (slot_len[ch][slot] > lim)
                    push_response(ST_SMALL, '0, 0, 1'b1);
                else
                begin
                    for (int i = 0; i < slot_len[ch][slot]; i++)
                        push_response(ST_READ, slot_data[ch][slot][i], slot_len[ch][slot],
                                      i == slot_len[ch][slot] - 1);
                    slot_full[ch][slot] = 1'b0;
                    tail_ptr[ch]        = (tail_ptr[ch] + 1) % N_SLOTS;
                end
            end
            default:
            begin
                // Unused command: no result, no state change.
            end
        endcase
    endfunction

    // True when a read would deliver a slot byte never written since reset.
    function automatic bit read_hits_unwritten(input int ch, input int cap);
        int slot;
        int lim;
        slot = tail_ptr[ch];
        lim  = (cap > MSG_MAX) ? MSG_MAX : cap;
        if (!slot_full[ch][slot] || slot_len[ch][slot] > lim)
            return 1'b0;
        for (int i = 0; i < slot_len[ch][slot]; i++)
            if (!slot_written[ch][slot][i])
                return 1'b1;
        return 1'b0;
    endfunction

    // Check result words and predict accepted words in mid-cycle, where all
    // ports are stable.
    always @(negedge clk)
    begin : monitor
        response_t want;
        if (rst_n && strobe)
        begin
            if (pending_responses.size() == 0)
                report_error($sformatf("unexpected result word status %0d byte %0h",
                                       status, out_byte));
            else
            begin
                want = pending_responses.pop_front();
                status_seen[want.status]++;
                if (status !== want.status)
                    report_error($sformatf("status %0d, expected %0d", status, want.status));
                if (out_byte !== want.data)
                    report_error($sformatf("out_byte %0h, expected %0h", out_byte, want.data));
                if (length !== want.len)
                    report_error($sformatf("length %0d, expected %0d", length, want.len));
                if (last !== want.fin)
                    report_error($sformatf("last %0b, expected %0b", last, want.fin));
            end
        end
        if (rst_n && start && !busy)
            predict_responses(command, channel, in_byte, end_of_message, read_capacity);
        taken <= rst_n && start && !busy;
    end

    // Sender pacing: random bursts, random gaps, now and then a long burst.
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 12);
        end
    endtask

    // Present one command word and hold it until the block takes it.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input int ch,
                             input logic [BYTE_W-1:0] data, input logic eom,
                             input logic [LEN_W-1:0] cap);
        start          <= 1'b1;
        command        <= cmd;
        channel        <= ch[CH_W-1:0];
        in_byte        <= data;
        end_of_message <= eom;
        read_capacity  <= cap;
        do
            @(posedge clk);
        while (!taken);
        if (cmd != CMD_UNUSED)
            items_sent++;
        pace_sender();
    endtask

    // Stream a message of random bytes; each byte may hop to another channel.
    task automatic send_message(input int ch, input int len, input int hop_pct);
        int c;
        c = ch;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < hop_pct)
                c = $urandom_range(0, N_CH - 1);
            send_item(CMD_WRITE, c, BYTE_W'($urandom), i == len - 1, LEN_W'($urandom));
        end
    endtask

    // Reads that would return never-written storage are left out.
    task automatic send_read(input int ch, input int cap);
        if (!read_hits_unwritten(ch, cap))
            send_item(CMD_READ, ch, BYTE_W'($urandom), 1'($urandom), cap[LEN_W-1:0]);
    endtask

    // Hold the sender off until every predicted word has come out.
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_responses.size() != 0);
    endtask

    // Reads of every channel while all queues are empty.
    task automatic test_empty_reads();
        send_read(0, 0);
        send_read(1, 127);
        send_read(2, 64);
        send_read(3, 1);
    endtask

    // One-byte messages with extreme bytes, read back at exact capacity.
    task automatic test_single_messages();
        send_item(CMD_WRITE, 0, 8'h00, 1'b1, 7'h00);
        send_item(CMD_WRITE, 1, 8'hA5, 1'b1, 7'h7F);
        send_item(CMD_WRITE, 2, 8'h5A, 1'b1, 7'h55);
        send_item(CMD_WRITE, 3, 8'hFF, 1'b1, 7'h2A);
        for (int c = 0; c < N_CH; c++)
            send_read(c, 1);
    endtask

    // Reader capacity below, at and above the message length.
    task automatic test_capacity();
        send_message(0, 3, 0);
        send_read(0, 2);
        send_read(0, 0);
        send_read(0, 3);
        send_message(0, 3, 0);
        send_read(0, 100);
    endtask

    // Fill one channel, overflow it, then commit into a slot freed mid-message.
    task automatic test_queue_full();
        for (int i = 0; i < N_SLOTS; i++)
            send_item(CMD_WRITE, 1, BYTE_W'($urandom), 1'b1, LEN_W'($urandom));
        send_message(1, 2, 0);
        // First byte is dropped; the read frees the slot before the last byte,
        // so the committed message carries the older byte at offset zero.
        send_item(CMD_WRITE, 1, BYTE_W'($urandom), 1'b0, LEN_W'($urandom));
        send_read(1, 64);
        send_item(CMD_WRITE, 1, BYTE_W'($urandom), 1'b1, LEN_W'($urandom));
        for (int i = 0; i <= N_SLOTS; i++)
            send_read(1, 127);
    endtask

    // Largest message, then one byte too many.
    task automatic test_long_messages();
        send_message(2, MSG_MAX, 0);
        send_read(2, MSG_MAX);
        send_message(2, MSG_MAX + 1, 0);
        send_read(2, 127);
    endtask

    // Channel hop within a message, unused command and clear mid-message.
    task automatic test_hop_and_clear();
        send_item(CMD_WRITE, 0, BYTE_W'($urandom), 1'b0, LEN_W'($urandom));
        send_item(CMD_WRITE, 3, BYTE_W'($urandom), 1'b1, LEN_W'($urandom));
        send_item(CMD_WRITE, 2, BYTE_W'($urandom), 1'b0, LEN_W'($urandom));
        send_item(CMD_UNUSED, 2, BYTE_W'($urandom), 1'b1, LEN_W'($urandom));
        send_item(CMD_CLEAR, 3, BYTE_W'($urandom), 1'b1, 7'h7F);
        send_item(CMD_WRITE, 1, BYTE_W'($urandom), 1'b1, LEN_W'($urandom));
        send_read(1, 1);
        send_read(3, 127);
    endtask

    // Mostly well-formed messages and reads, with partial messages, clears
    // and unused commands as noise. Halfway through the sender drains once.
    task automatic test_random_traffic();
        int target;
        int pick;
        int ch;
        int len;
        int cap;
        bit drained;
        target  = items_sent + RANDOM_ITEMS;
        drained = 1'b0;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            ch   = $urandom_range(0, N_CH - 1);
            if (!drained && items_sent >= target - RANDOM_ITEMS / 2)
            begin
                wait_for_results();
                drained = 1'b1;
            end
            if (pick < 50)
            begin
                len = $urandom_range(0, 99);
                if (len < 2)
                    len = $urandom_range(MSG_MAX + 1, MSG_MAX + 4);
                else if (len < 5)
                    len = $urandom_range(MSG_MAX - 4, MSG_MAX);
                else
                    len = $urandom_range(1, 6);
                send_message(ch, len, 8);
            end
            else if (pick < 85)
            begin
                cap = $urandom_range(0, 99);
                if (cap < 25)
                    cap = $urandom_range(0, 127);
                else if (cap < 40)
                    cap = $urandom_range(0, 3);
                else
                    cap = $urandom_range(MSG_MAX, 127);
                send_read(ch, cap);
            end
            else if (pick < 90)
                send_item(CMD_CLEAR, ch, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
            else if (pick < 95)
                send_item(CMD_UNUSED, ch, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
            else
            begin
                // Partial message: its bytes run into whatever write comes next.
                repeat ($urandom_range(1, 3))
                    send_item(CMD_WRITE, ch, BYTE_W'($urandom), 1'b0, LEN_W'($urandom));
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_reads();
        test_single_messages();
        test_capacity();
        test_queue_full();
        test_long_messages();
        test_hop_and_clear();
        test_random_traffic();

        wait_for_results();
        repeat (20) @(posedge clk);
        if (pending_responses.size() != 0)
            report_error($sformatf("%0d result words never arrived",
                                   pending_responses.size()));

        $display("Run covered %0d command words: %0d messages committed, %0d bytes read",
                 items_sent, status_seen[ST_WRITTEN], status_seen[ST_READ]);
        $display("Refusals: %0d empty, %0d too small, %0d full, %0d too long; %0d clears",
                 status_seen[ST_EMPTY], status_seen[ST_SMALL], status_seen[ST_FULL],
                 status_seen[ST_LONG], status_seen[ST_CLEARED]);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
